FILE: src/hmmq_pkg.sv
// ----------------------------------------------------------------------------
// hmmq_pkg
// Shared constants, types and helpers of the histogram summary block.
// ----------------------------------------------------------------------------
package hmmq_pkg;

  localparam int MAX_BINS   = 512;
  localparam int ADDR_W     = $clog2(MAX_BINS);
  localparam int N_W        = ADDR_W + 1;
  localparam int PROD_W     = N_W + 34;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [1:0] REG_BIN_COUNT_USED = 2'd0;
  localparam logic [1:0] REG_RANGE_MIN      = 2'd1;
  localparam logic [1:0] REG_RANGE_MAX      = 2'd2;
  localparam logic [1:0] REG_TAIL_DROP      = 2'd3;

  localparam logic [1:0] SEL_MODE   = 2'd0;
  localparam logic [1:0] SEL_MEDIAN = 2'd1;
  localparam logic [1:0] SEL_LOWER  = 2'd2;
  localparam logic [1:0] SEL_UPPER  = 2'd3;

  typedef struct packed {
    logic [31:0]       count;
    logic [ADDR_W-1:0] addr;
    logic              last;
  } fifo_entry_t;

  typedef struct packed {
    logic           start;
    logic [N_W-1:0] idx;
    logic [N_W-1:0] n;
  } ctr_req_t;

  typedef struct packed {
    logic               mode_valid;
    logic [8:0]         mode_bin;
    logic signed [31:0] mode_value;
    logic [8:0]         median_bin;
    logic signed [31:0] median_value;
    logic [9:0]         lower_bin;
    logic signed [31:0] lower_value;
    logic [8:0]         upper_bin;
    logic signed [31:0] upper_value;
  } result_t;

  typedef enum logic [2:0] {
    B_LOAD, B_SCAN, B_MED_RD, B_MED_ACC, B_CTR_GO, B_CTR_WAIT, B_HOLD
  } back_state_e;

  typedef enum logic [1:0] {
    C_IDLE, C_MUL, C_DIV, C_FIN
  } ctr_state_e;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [N_W-1:0] eff_bins(input logic [9:0] used);
    if (used == 10'd0) begin
      return N_W'(1);
    end else if (int'(used) > MAX_BINS) begin
      return N_W'(MAX_BINS);
    end
    return N_W'(used);
  endfunction

endpackage

FILE: src/hmmq_front.sv
// ----------------------------------------------------------------------------
// hmmq_front
// Accepts bin counts, numbers them and marks the last bin of each histogram.
// ----------------------------------------------------------------------------
module hmmq_front import hmmq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              bin_valid_i,
  input  logic [31:0]       bin_count_i,
  input  logic [N_W-1:0]    n_i,
  input  logic              fifo_full_i,
  output logic              bin_stall_o,
  output logic              push_o,
  output fifo_entry_t       entry_o
);

  logic [ADDR_W-1:0] load_index_q, load_index_d;
  logic              last;

  assign bin_stall_o = fifo_full_i;
  assign push_o      = bin_valid_i && !fifo_full_i;
  assign last        = ({1'b0, load_index_q} + N_W'(1)) >= n_i;

  assign entry_o.count = bin_count_i;
  assign entry_o.addr  = load_index_q;
  assign entry_o.last  = last;

  always_comb begin
    load_index_d = load_index_q;
    if (push_o) begin
      load_index_d = last ? '0 : load_index_q + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_index_q <= '0;
    end else begin
      load_index_q <= load_index_d;
    end
  end

endmodule

FILE: src/hmmq_fifo.sv
// ----------------------------------------------------------------------------
// hmmq_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module hmmq_fifo import hmmq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  fifo_entry_t wdata_i,
  input  logic        pop_i,
  output fifo_entry_t rdata_o,
  output logic        full_o,
  output logic        empty_o
);

  fifo_entry_t             mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_PTR_W:0]     cnt_q, cnt_d;

  assign full_o  = cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + FIFO_PTR_W'(1) : wr_q;
    rd_d  = pop_i ? rd_q + FIFO_PTR_W'(1) : rd_q;
    cnt_d = cnt_q + (FIFO_PTR_W+1)'(push_i) - (FIFO_PTR_W+1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: src/hmmq_centre.sv
// ----------------------------------------------------------------------------
// hmmq_centre
// Bin-centre unit: one multiply, a bit-serial floor division by twice the
// bin count, then an add of the lower edge with saturation.
// ----------------------------------------------------------------------------
module hmmq_centre import hmmq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctr_req_t           req_i,
  input  logic signed [31:0] range_min_i,
  input  logic signed [31:0] range_max_i,
  output logic               done_o,
  output logic signed [31:0] value_o
);

  localparam int CNT_W = $clog2(PROD_W + 1);

  ctr_state_e state_q, state_d;

  logic signed [PROD_W-1:0] prod_q;
  logic [PROD_W-1:0]        mag_q;
  logic [N_W+1:0]           rem_q;
  logic [N_W:0]             den_q;
  logic                     neg_q;
  logic [CNT_W-1:0]         cnt_q;

  logic signed [32:0]       diff;
  logic [N_W:0]             odd;
  logic [N_W+1:0]           trial;
  logic signed [PROD_W:0]   quot;
  logic signed [PROD_W+1:0] sum;

  assign diff  = 33'(range_max_i) - 33'(range_min_i);
  assign odd   = {req_i.idx, 1'b1};
  assign trial = {rem_q[N_W:0], mag_q[PROD_W-1]};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      C_IDLE:  if (req_i.start) state_d = C_MUL;
      C_MUL:   state_d = C_DIV;
      C_DIV:   if (cnt_q == CNT_W'(PROD_W - 1)) state_d = C_FIN;
      C_FIN:   state_d = C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  always_comb begin
    quot = mag_q[PROD_W-1:0] + (PROD_W+1)'(rem_q != '0);
    quot = neg_q ? -quot : $signed({1'b0, mag_q});
    sum  = (PROD_W+2)'(range_min_i) + (PROD_W+2)'(quot);
    done_o = state_q == C_FIN;
    if (sum > (PROD_W+2)'(32'sh7FFF_FFFF)) begin
      value_o = 32'sh7FFF_FFFF;
    end else if (sum < -(PROD_W+2)'(33'sh0_8000_0000)) begin
      value_o = 32'sh8000_0000;
    end else begin
      value_o = sum[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      C_IDLE: begin
        prod_q <= $signed({{(PROD_W-N_W-1){1'b0}}, odd})
                  * $signed({{(PROD_W-33){diff[32]}}, diff});
        den_q  <= {req_i.n, 1'b0};
      end
      C_MUL: begin
        neg_q <= prod_q[PROD_W-1];
        mag_q <= prod_q[PROD_W-1] ? -prod_q : prod_q;
        rem_q <= '0;
        cnt_q <= '0;
      end
      C_DIV: begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (trial >= (N_W+2)'(den_q)) begin
          rem_q <= trial - (N_W+2)'(den_q);
          mag_q <= {mag_q[PROD_W-2:0], 1'b1};
        end else begin
          rem_q <= trial;
          mag_q <= {mag_q[PROD_W-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/hmmq_back.sv
// ----------------------------------------------------------------------------
// hmmq_back
// Bin store and evaluation sequencer: mode and both bounds in one scan, the
// median walk, the four centre values, and the result register.
// ----------------------------------------------------------------------------
module hmmq_back import hmmq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fifo_entry_t        entry_i,
  input  logic               empty_i,
  output logic               pop_o,
  input  logic [N_W-1:0]     n_i,
  input  logic signed [31:0] range_min_i,
  input  logic signed [31:0] range_max_i,
  input  logic [31:0]        tail_drop_i,
  output logic               res_valid_o,
  input  logic               res_stall_i,
  output result_t            res_o
);

  back_state_e state_q, state_d;

  logic [31:0]       store_q [MAX_BINS];
  logic [31:0]       rd_a_q, rd_b_q;
  logic [ADDR_W-1:0] ra, rb;

  logic [N_W-1:0]    k_q;
  logic              p_vld_q;
  logic [ADDR_W-1:0] p_idx_q;
  logic [ADDR_W-1:0] last_idx, ib;
  logic              issue;

  logic [31:0]       best_q, front_q, back_q;
  logic [ADDR_W-1:0] best_idx_q;
  logic              mval_q;
  logic              lo_done_q, up_done_q;
  logic [N_W-1:0]    lo_bin_q;
  logic [ADDR_W-1:0] up_bin_q;
  logic [ADDR_W-1:0] mi_q, mj_q;
  logic              side_q;
  logic [31:0]       lo_sum, up_sum;
  logic              scan_end;

  logic [1:0]         sel_q;
  logic signed [31:0] val_q [4];
  ctr_req_t           req;
  logic               ctr_done;
  logic signed [31:0] ctr_value;

  logic    out_valid_q;
  result_t res_q;

  assign last_idx = ADDR_W'(n_i - N_W'(1));
  assign ib       = last_idx - p_idx_q;
  assign issue    = state_q == B_SCAN && k_q < n_i;
  assign scan_end = p_vld_q && p_idx_q == last_idx;
  assign lo_sum   = sat_add(rd_a_q, front_q);
  assign up_sum   = sat_add(rd_b_q, back_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_LOAD:     if (!empty_i && entry_i.last) state_d = B_SCAN;
      B_SCAN:     if (scan_end) state_d = B_MED_RD;
      B_MED_RD:   state_d = (mi_q == mj_q) ? B_CTR_GO : B_MED_ACC;
      B_MED_ACC:  state_d = B_MED_RD;
      B_CTR_GO:   state_d = B_CTR_WAIT;
      B_CTR_WAIT: if (ctr_done) state_d = (sel_q == SEL_UPPER) ? B_HOLD : B_CTR_GO;
      B_HOLD:     if (!out_valid_q) state_d = B_LOAD;
      default:    state_d = B_LOAD;
    endcase
  end

  always_comb begin
    pop_o     = state_q == B_LOAD && !empty_i;
    req.start = state_q == B_CTR_GO;
    req.n     = n_i;
    ra        = k_q[ADDR_W-1:0];
    rb        = last_idx - k_q[ADDR_W-1:0];
    if (state_q == B_MED_RD) begin
      ra = (front_q < back_q) ? mi_q : mj_q;
    end
    case (sel_q)
      SEL_MODE:   req.idx = N_W'(best_idx_q);
      SEL_MEDIAN: req.idx = N_W'(mi_q);
      SEL_LOWER:  req.idx = lo_bin_q;
      default:    req.idx = N_W'(up_bin_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      store_q[entry_i.addr] <= entry_i.count;
    end
    rd_a_q <= store_q[ra];
    rd_b_q <= store_q[rb];
  end

  hmmq_centre u_centre (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .range_min_i (range_min_i),
    .range_max_i (range_max_i),
    .done_o      (ctr_done),
    .value_o     (ctr_value)
  );

  always_ff @(posedge clk_i) begin
    p_idx_q <= k_q[ADDR_W-1:0];
    if (issue) begin
      k_q <= k_q + N_W'(1);
    end
    case (state_q)
      B_LOAD: begin
        k_q        <= '0;
        best_q     <= '0;
        best_idx_q <= '0;
        mval_q     <= 1'b0;
        front_q    <= '0;
        back_q     <= '0;
        lo_done_q  <= 1'b0;
        up_done_q  <= 1'b0;
        lo_bin_q   <= n_i;
        up_bin_q   <= '0;
      end
      B_SCAN: begin
        if (p_vld_q) begin
          if (rd_a_q > best_q) begin
            best_q     <= rd_a_q;
            best_idx_q <= p_idx_q;
            mval_q     <= 1'b1;
          end
          if (!lo_done_q) begin
            if (lo_sum >= tail_drop_i) begin
              lo_done_q <= 1'b1;
              lo_bin_q  <= N_W'(p_idx_q);
            end else if (!scan_end) begin
              front_q <= lo_sum;
            end
          end
          if (!up_done_q) begin
            if (ib == '0 || up_sum >= tail_drop_i) begin
              up_done_q <= 1'b1;
              up_bin_q  <= ib;
            end else if (!scan_end) begin
              back_q <= up_sum;
            end
          end
        end
        if (scan_end) begin
          front_q <= '0;
          back_q  <= '0;
          mi_q    <= '0;
          mj_q    <= last_idx;
        end
      end
      B_MED_RD: begin
        side_q <= front_q < back_q;
        sel_q  <= SEL_MODE;
      end
      B_MED_ACC: begin
        if (side_q) begin
          front_q <= sat_add(front_q, rd_a_q);
          mi_q    <= mi_q + ADDR_W'(1);
        end else begin
          back_q <= sat_add(back_q, rd_a_q);
          mj_q   <= mj_q - ADDR_W'(1);
        end
      end
      B_CTR_WAIT: begin
        if (ctr_done) begin
          val_q[sel_q] <= ctr_value;
          sel_q        <= sel_q + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_LOAD;
      p_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      p_vld_q <= issue;
      if (state_q == B_HOLD && !out_valid_q) begin
        out_valid_q <= 1'b1;
      end else if (!res_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_HOLD && !out_valid_q) begin
      res_q.mode_valid   <= mval_q;
      res_q.mode_bin     <= mval_q ? 9'(best_idx_q) : 9'd0;
      res_q.mode_value   <= mval_q ? val_q[SEL_MODE] : 32'sd0;
      res_q.median_bin   <= 9'(mi_q);
      res_q.median_value <= val_q[SEL_MEDIAN];
      res_q.lower_bin    <= 10'(lo_bin_q);
      res_q.lower_value  <= val_q[SEL_LOWER];
      res_q.upper_bin    <= 9'(up_bin_q);
      res_q.upper_value  <= val_q[SEL_UPPER];
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

FILE: src/histogram_mode_median_quantiles.sv
// ----------------------------------------------------------------------------
// histogram_mode_median_quantiles
// Mode, median and tail bounds of one histogram of bin counts.
//
// The input channel (bin_valid_i, bin_stall_o, bin_count_i) takes one bin
// count per item, lowest bin first. After the last of bin_count_used items
// the output channel (res_valid_o, res_stall_i) gives one result item.
// Items enter at one per cycle into a four-entry queue while it is not
// full, and are written to the bin store at one per cycle while the back
// is loading. The final item starts an evaluation: the forward and backward
// scan, the median walk (n - 1 steps), and the four centre values in the
// shared bit-serial divider. Counts of the next histogram are queued while
// the evaluation runs, until the queue is full. A stalled result holds in
// the output register and the store keeps loading behind it. Reset clears
// the control state and loads the register defaults; the bin store holds no
// valid data until it is written. Registers sit on the APB port at byte
// addresses 0, 4, 8, 12.
// ----------------------------------------------------------------------------
module histogram_mode_median_quantiles import hmmq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               bin_valid_i,
  output logic               bin_stall_o,
  input  logic [31:0]        bin_count_i,
  output logic               res_valid_o,
  input  logic               res_stall_i,
  output logic               mode_valid_o,
  output logic [8:0]         mode_bin_o,
  output logic signed [31:0] mode_value_o,
  output logic [8:0]         median_bin_o,
  output logic signed [31:0] median_value_o,
  output logic [9:0]         lower_bin_o,
  output logic signed [31:0] lower_value_o,
  output logic [8:0]         upper_bin_o,
  output logic signed [31:0] upper_value_o
);

  logic [9:0]         bin_count_used_q;
  logic signed [31:0] range_min_q, range_max_q;
  logic [31:0]        tail_drop_q;
  logic               wr_en;
  logic [N_W-1:0]     n_eff;

  logic        push, pop, full, empty;
  fifo_entry_t wr_entry, rd_entry;
  result_t     res;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign n_eff  = eff_bins(bin_count_used_q);

  always_comb begin
    unique case (paddr[3:2])
      REG_BIN_COUNT_USED: prdata = {22'd0, bin_count_used_q};
      REG_RANGE_MIN:      prdata = range_min_q;
      REG_RANGE_MAX:      prdata = range_max_q;
      REG_TAIL_DROP:      prdata = tail_drop_q;
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_count_used_q <= 10'd500;
      range_min_q      <= 32'sd0;
      range_max_q      <= 32'sd65536000;
      tail_drop_q      <= 32'd0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_BIN_COUNT_USED: bin_count_used_q <= pwdata[9:0];
        REG_RANGE_MIN:      range_min_q      <= pwdata;
        REG_RANGE_MAX:      range_max_q      <= pwdata;
        REG_TAIL_DROP:      tail_drop_q      <= pwdata;
        default: begin
        end
      endcase
    end
  end

  hmmq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bin_valid_i (bin_valid_i),
    .bin_count_i (bin_count_i),
    .n_i         (n_eff),
    .fifo_full_i (full),
    .bin_stall_o (bin_stall_o),
    .push_o      (push),
    .entry_o     (wr_entry)
  );

  hmmq_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wr_entry),
    .pop_i   (pop),
    .rdata_o (rd_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  hmmq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (rd_entry),
    .empty_i     (empty),
    .pop_o       (pop),
    .n_i         (n_eff),
    .range_min_i (range_min_q),
    .range_max_i (range_max_q),
    .tail_drop_i (tail_drop_q),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .res_o       (res)
  );

  assign mode_valid_o   = res.mode_valid;
  assign mode_bin_o     = res.mode_bin;
  assign mode_value_o   = res.mode_value;
  assign median_bin_o   = res.median_bin;
  assign median_value_o = res.median_value;
  assign lower_bin_o    = res.lower_bin;
  assign lower_value_o  = res.lower_value;
  assign upper_bin_o    = res.upper_bin;
  assign upper_value_o  = res.upper_value;

  a_mode_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !mode_valid_o |-> mode_bin_o == 9'd0 && mode_value_o == 32'sd0)
    else $error("invalid mode carries a nonzero bin or value");

  a_lower_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> {22'd0, lower_bin_o} <= 32'(MAX_BINS))
    else $error("lower bound bin beyond the bin count");

  a_pop_only_when_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("queue popped while empty");

endmodule

FILE: tb/hmmq_checker.sv
// ----------------------------------------------------------------------------
// hmmq_checker
// Watches the register port and both item channels of the histogram summary
// block. It keeps its own copy of the registers and the bin store, works out
// the mode, median and tail bounds when a histogram completes, and compares
// every result item field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module hmmq_checker import hmmq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               bin_valid_i,
  input  logic               bin_stall_i,
  input  logic [31:0]        bin_count_i,
  input  logic               res_valid_i,
  input  logic               res_stall_i,
  input  logic               mode_valid_i,
  input  logic [8:0]         mode_bin_i,
  input  logic signed [31:0] mode_value_i,
  input  logic [8:0]         median_bin_i,
  input  logic signed [31:0] median_value_i,
  input  logic [9:0]         lower_bin_i,
  input  logic signed [31:0] lower_value_i,
  input  logic [8:0]         upper_bin_i,
  input  logic signed [31:0] upper_value_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  logic [9:0]         bins_used;
  logic signed [31:0] edge_lo;
  logic signed [31:0] edge_hi;
  logic [31:0]        drop;
  logic [31:0]        hist_store [MAX_BINS];
  int unsigned        fill_idx;
  result_t            summary_q [$];

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic int unsigned bins_in_use();
    if (bins_used == 10'd0) return 1;
    if (int'(bins_used) > MAX_BINS) return MAX_BINS;
    return int'(bins_used);
  endfunction

  function automatic logic signed [31:0] bin_centre(input int unsigned idx,
                                                   input int unsigned nb);
    longint diff, num, den, q, v;
    diff = longint'(edge_hi) - longint'(edge_lo);
    num = longint'(2 * idx + 1) * diff;
    den = longint'(nb) * 2;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    v = longint'(edge_lo) + q;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic result_t summarize(input int unsigned nb);
    result_t     r;
    logic [31:0] best, fsum, bsum;
    int unsigned bi, i, j;
    logic        found;
    best = 0;
    bi = 0;
    found = 1'b0;
    for (i = 0; i < nb; i++) begin
      if (hist_store[i] > best) begin
        best = hist_store[i];
        bi = i;
        found = 1'b1;
      end
    end
    r.mode_valid = found;
    r.mode_bin = found ? bi[8:0] : 9'd0;
    r.mode_value = found ? bin_centre(bi, nb) : 32'sd0;

    i = 0;
    j = nb - 1;
    fsum = 0;
    bsum = 0;
    while (i != j) begin
      if (fsum < bsum) begin
        fsum = add_sat(fsum, hist_store[i]);
        i++;
      end else begin
        bsum = add_sat(bsum, hist_store[j]);
        j--;
      end
    end
    r.median_bin = i[8:0];
    r.median_value = bin_centre(i, nb);

    i = 0;
    fsum = 0;
    while (i < nb && fsum < drop) begin
      if (add_sat(hist_store[i], fsum) >= drop) break;
      fsum = add_sat(fsum, hist_store[i]);
      i++;
    end
    r.lower_bin = i[9:0];
    r.lower_value = bin_centre(i, nb);

    i = nb - 1;
    bsum = 0;
    while (i > 0 && bsum < drop) begin
      if (add_sat(hist_store[i], bsum) >= drop) break;
      bsum = add_sat(bsum, hist_store[i]);
      i--;
    end
    r.upper_bin = i[8:0];
    r.upper_value = bin_centre(i, nb);
    return r;
  endfunction

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    int unsigned nb;
    if (!rst_ni) begin
      bins_used = 10'd500;
      edge_lo = 32'sd0;
      edge_hi = 32'sd65536000;
      drop = 32'd0;
      fill_idx = 0;
      summary_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_BIN_COUNT_USED: bins_used = pwdata[9:0];
          REG_RANGE_MIN:      edge_lo = pwdata;
          REG_RANGE_MAX:      edge_hi = pwdata;
          REG_TAIL_DROP:      drop = pwdata;
          default: ;
        endcase
      end
      if (res_valid_i && !res_stall_i) begin
        if (summary_q.size() == 0) begin
          $error("result item arrived with no histogram outstanding");
          fail_count_o++;
        end else begin
          want = summary_q.pop_front();
          compare_field("mode_valid", want.mode_valid, mode_valid_i);
          compare_field("mode_bin", want.mode_bin, mode_bin_i);
          compare_field("mode_value", want.mode_value, mode_value_i);
          compare_field("median_bin", want.median_bin, median_bin_i);
          compare_field("median_value", want.median_value, median_value_i);
          compare_field("lower_bin", want.lower_bin, lower_bin_i);
          compare_field("lower_value", want.lower_value, lower_value_i);
          compare_field("upper_bin", want.upper_bin, upper_bin_i);
          compare_field("upper_value", want.upper_value, upper_value_i);
        end
      end
      if (bin_valid_i && !bin_stall_i) begin
        nb = bins_in_use();
        if (fill_idx < MAX_BINS) hist_store[fill_idx] = bin_count_i;
        if (fill_idx + 1 < nb) begin
          fill_idx++;
        end else begin
          fill_idx = 0;
          summary_q.insert(summary_q.size(), summarize(nb));
        end
      end
    end
    pending_o = summary_q.size();
  end

endmodule

FILE: tb/tb_histogram_mode_median_quantiles.sv
// ----------------------------------------------------------------------------
// tb_histogram_mode_median_quantiles
// Drives histograms of bin counts into the summary block under several
// register settings, with random gaps and output stalls, and reports the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_histogram_mode_median_quantiles import hmmq_pkg::*; ();

  localparam int CYCLE_LIMIT = 600000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = 4'd0;
  logic [31:0]        pwdata = 32'd0;
  logic [31:0]        prdata;
  logic               pready;
  logic               bin_valid = 1'b0;
  logic               bin_stall;
  logic [31:0]        bin_count = 32'd0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  logic               mode_valid;
  logic [8:0]         mode_bin;
  logic signed [31:0] mode_value;
  logic [8:0]         median_bin;
  logic signed [31:0] median_value;
  logic [9:0]         lower_bin;
  logic signed [31:0] lower_value;
  logic [8:0]         upper_bin;
  logic signed [31:0] upper_value;
  int                 fail_count;
  int                 pending;
  int                 cycles = 0;
  logic               quiet = 1'b0;

  histogram_mode_median_quantiles dut (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .bin_valid_i(bin_valid), .bin_stall_o(bin_stall), .bin_count_i(bin_count),
    .res_valid_o(res_valid), .res_stall_i(res_stall),
    .mode_valid_o(mode_valid), .mode_bin_o(mode_bin), .mode_value_o(mode_value),
    .median_bin_o(median_bin), .median_value_o(median_value),
    .lower_bin_o(lower_bin), .lower_value_o(lower_value),
    .upper_bin_o(upper_bin), .upper_value_o(upper_value)
  );

  hmmq_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .bin_valid_i(bin_valid), .bin_stall_i(bin_stall), .bin_count_i(bin_count),
    .res_valid_i(res_valid), .res_stall_i(res_stall),
    .mode_valid_i(mode_valid), .mode_bin_i(mode_bin), .mode_value_i(mode_value),
    .median_bin_i(median_bin), .median_value_i(median_value),
    .lower_bin_i(lower_bin), .lower_value_i(lower_value),
    .upper_bin_i(upper_bin), .upper_value_i(upper_value),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    res_stall <= !quiet && ($urandom_range(99) < 10);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_histogram_mode_median_quantiles NOT OK");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Registers change only once every histogram has been summarized.
  task automatic setup(input logic [9:0] n, input logic [31:0] lo, input logic [31:0] hi,
                       input logic [31:0] td);
    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    write_reg(REG_BIN_COUNT_USED, {22'd0, n});
    write_reg(REG_RANGE_MIN, lo);
    write_reg(REG_RANGE_MAX, hi);
    write_reg(REG_TAIL_DROP, td);
  endtask

  task automatic send_bin(input logic [31:0] value);
    logic stalled;
    if (!quiet && $urandom_range(99) < 3) begin
      bin_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    bin_valid <= 1'b1;
    bin_count <= value;
    forever begin
      @(negedge clk);
      stalled = bin_stall;
      @(posedge clk);
      if (!stalled) break;
    end
  endtask

  function automatic logic [31:0] random_count();
    case ($urandom_range(11))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(0, 200);
    endcase
  endfunction

  function automatic logic [31:0] random_drop();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return $urandom;
      2: return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 600);
    endcase
  endfunction

  initial begin
    logic [31:0] lo, hi;
    int n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // A zero bin count acts as a single bin per histogram.
    setup(10'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
    send_bin(32'd0);
    send_bin(32'hFFFF_FFFF);
    bin_valid <= 1'b0;

    // Reversed full range, saturating sums and ties for the mode.
    setup(10'd10, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    for (int k = 0; k < 10; k++) send_bin((k % 2 == 0) ? 32'hFFFF_FFFF : 32'(k));
    // All counts zero leaves the mode invalid and the lower bound at n.
    for (int k = 0; k < 10; k++) send_bin(32'd0);
    bin_valid <= 1'b0;

    // An oversize bin count clamps to the largest histogram, sent back to back.
    quiet <= 1'b1;
    setup(10'd1023, $urandom, $urandom, random_drop());
    for (int k = 0; k < MAX_BINS; k++) send_bin(random_count());
    bin_valid <= 1'b0;
    quiet <= 1'b0;

    for (int p = 0; p < 14; p++) begin
      n = $urandom_range(10, 16);
      case ($urandom_range(3))
        0: begin lo = $urandom; hi = $urandom; end
        1: begin lo = $urandom_range(0, 200) << 16; hi = lo + ($urandom_range(1, 900) << 16); end
        2: begin hi = $urandom_range(0, 200) << 16; lo = hi + ($urandom_range(1, 900) << 16); end
        default: begin lo = $urandom; hi = lo; end
      endcase
      setup(10'(n), lo, hi, random_drop());
      for (int h = 0; h < 3; h++) begin
        for (int k = 0; k < n; k++) send_bin(random_count());
      end
      bin_valid <= 1'b0;
    end

    @(posedge clk);
    wait (pending == 0);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_histogram_mode_median_quantiles OK");
    end else begin
      $display("tb_histogram_mode_median_quantiles NOT OK");
    end
    $finish;
  end

endmodule

FILE: histogram_mode_median_quantiles.f
src/hmmq_pkg.sv
src/hmmq_front.sv
src/hmmq_fifo.sv
src/hmmq_centre.sv
src/hmmq_back.sv
src/histogram_mode_median_quantiles.sv
tb/hmmq_checker.sv
tb/tb_histogram_mode_median_quantiles.sv
